// ----- rtl/upe_pkg.sv -----
// Shared types, constants and helper functions of the update period estimator.
// Depends on nothing; every other file takes what it needs by scoped names.
package upe_pkg;

   localparam int RING_DEPTH = 12;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int IV_W       = 31;

   localparam logic [1:0] CMD_OBSERVE = 2'd0;
   localparam logic [1:0] CMD_QUERY   = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   localparam logic [1:0] CSR_MANUAL    = 2'd0;
   localparam logic [1:0] CSR_START_REM = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [5:0] MAN_AUTO = 6'd0;
   localparam logic [5:0] MAN_10   = 6'd10;
   localparam logic [5:0] MAN_20   = 6'd20;
   localparam logic [5:0] MAN_30   = 6'd30;
   localparam logic [5:0] MAN_60   = 6'd60;

   localparam logic [7:0]  MAX_CYCLE       = 8'd240;
   localparam logic [15:0] THRESHOLD_RESET = 16'd5;
   localparam logic [21:0] DELAY_UNKNOWN   = 22'd600000;
   localparam logic [21:0] DELAY_MIN       = 22'd60000;
   localparam logic [21:0] DELAY_MAX       = 22'd3900000;

   typedef struct packed {
      logic             go;
      logic [CNT_W-1:0] filled;
      logic [IDX_W-1:0] wp;
   } upe_scan_ctl_type;

   typedef struct packed {
      logic            done;
      logic            stable;
      logic [IV_W-1:0] median;
   } upe_scan_stat_type;

   // Nearest of 600/1200/1800/3600 s; a tie goes to the smaller point.
   function automatic logic [1:0] snap_idx(input logic [IV_W-1:0] secs);
      logic [1:0] k;
      if (secs <= IV_W'(900)) begin
         k = 2'd0;
      end else if (secs <= IV_W'(1500)) begin
         k = 2'd1;
      end else if (secs <= IV_W'(2700)) begin
         k = 2'd2;
      end else begin
         k = 2'd3;
      end
      return k;
   endfunction

   function automatic logic [7:0] snap_minutes(input logic [1:0] k);
      logic [7:0] m;
      unique case (k)
         2'd0:    m = 8'd10;
         2'd1:    m = 8'd20;
         2'd2:    m = 8'd30;
         default: m = 8'd60;
      endcase
      return m;
   endfunction

endpackage

// ----- rtl/upe_ring.sv -----
// Interval ring storage: one write port, one read port with registered data.
// Depends on upe_pkg for depth and width.
module upe_ring (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [upe_pkg::IDX_W-1:0]   wr_addr,
   input  logic [upe_pkg::IV_W-1:0]    wr_data,
   input  logic [upe_pkg::IDX_W-1:0]   rd_addr,
   output logic [upe_pkg::IV_W-1:0]    rd_data
);

   logic [upe_pkg::IV_W-1:0] mem [upe_pkg::RING_DEPTH];
   logic [upe_pkg::IV_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/upe_scan.sv -----
// Ring scan sequencer: stability check over the newest three intervals, then
// a rank-count median with one shared comparator. Depends on upe_pkg.
module upe_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  upe_pkg::upe_scan_ctl_type     ctl,
   output upe_pkg::upe_scan_stat_type    stat,
   output logic [upe_pkg::IDX_W-1:0]     rd_addr,
   input  logic [upe_pkg::IV_W-1:0]      rd_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_ST0, S_ST1, S_ST2, S_ST3, S_CRD, S_CLD, S_CMP, S_FIN
   } state_type;

   state_type                  state_ff;
   logic [upe_pkg::CNT_W-1:0]  n_ff;
   logic [upe_pkg::IDX_W-1:0]  wp_ff;
   logic [upe_pkg::IDX_W-1:0]  ci_ff;
   logic [upe_pkg::IDX_W-1:0]  cj_ff;
   logic [upe_pkg::CNT_W-1:0]  rank_ff;
   logic [upe_pkg::IV_W-1:0]   cand_ff;
   logic [upe_pkg::IV_W-1:0]   lo_ff;
   logic [upe_pkg::IV_W-1:0]   hi_ff;
   logic [1:0]                 k0_ff;
   logic [1:0]                 k1_ff;
   logic                       done_ff;
   logic                       stable_ff;
   logic [upe_pkg::IV_W-1:0]   median_ff;

   logic [upe_pkg::CNT_W-1:0]  hi_rank;
   logic [upe_pkg::CNT_W-1:0]  lo_rank;
   logic [upe_pkg::CNT_W-1:0]  rank_in;
   logic                       less;
   logic                       last_j;
   logic [upe_pkg::IV_W:0]     pair_sum;

   // Ring slot of the i-th newest-three interval, oldest first.
   function automatic logic [upe_pkg::IDX_W-1:0] stab_idx(
      input logic [upe_pkg::IDX_W-1:0] wp,
      input logic [1:0]                i
   );
      logic [upe_pkg::IDX_W:0] s;
      s = {1'b0, wp} + (upe_pkg::IDX_W+1)'(upe_pkg::RING_DEPTH - 3)
          + (upe_pkg::IDX_W+1)'(i);
      if (s >= (upe_pkg::IDX_W+1)'(upe_pkg::RING_DEPTH)) begin
         s = s - (upe_pkg::IDX_W+1)'(upe_pkg::RING_DEPTH);
      end
      return s[upe_pkg::IDX_W-1:0];
   endfunction

   assign hi_rank  = n_ff >> 1;
   assign lo_rank  = hi_rank - upe_pkg::CNT_W'(1);
   assign last_j   = (upe_pkg::CNT_W'(cj_ff) == n_ff - upe_pkg::CNT_W'(1));
   // Equal values rank by slot so every rank is taken exactly once.
   assign less     = (rd_data < cand_ff) || ((rd_data == cand_ff) && (cj_ff < ci_ff));
   assign rank_in  = rank_ff + upe_pkg::CNT_W'(less);
   assign pair_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   always_comb begin
      unique case (state_ff)
         S_ST0:   rd_addr = stab_idx(wp_ff, 2'd0);
         S_ST1:   rd_addr = stab_idx(wp_ff, 2'd1);
         S_ST2:   rd_addr = stab_idx(wp_ff, 2'd2);
         S_CRD:   rd_addr = ci_ff;
         S_CMP:   rd_addr = last_j ? '0 : cj_ff + upe_pkg::IDX_W'(1);
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         done_ff   <= 1'b0;
         stable_ff <= 1'b0;
      end else begin
         done_ff <= ((state_ff == S_IDLE) && ctl.go && (ctl.filled < upe_pkg::CNT_W'(3)))
                    || (state_ff == S_FIN);
         unique case (state_ff)
            S_IDLE: begin
               if (ctl.go) begin
                  n_ff  <= ctl.filled;
                  wp_ff <= ctl.wp;
                  if (ctl.filled < upe_pkg::CNT_W'(3)) begin
                     stable_ff <= 1'b0;
                  end else begin
                     state_ff <= S_ST0;
                  end
               end
            end
            S_ST0: state_ff <= S_ST1;
            S_ST1: begin
               k0_ff    <= upe_pkg::snap_idx(rd_data);
               state_ff <= S_ST2;
            end
            S_ST2: begin
               k1_ff    <= upe_pkg::snap_idx(rd_data);
               state_ff <= S_ST3;
            end
            S_ST3: begin
               stable_ff <= (k0_ff == k1_ff) && (k1_ff == upe_pkg::snap_idx(rd_data));
               ci_ff     <= '0;
               state_ff  <= S_CRD;
            end
            S_CRD: state_ff <= S_CLD;
            S_CLD: begin
               cand_ff  <= rd_data;
               cj_ff    <= '0;
               rank_ff  <= '0;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (last_j) begin
                  if (rank_in == hi_rank) begin
                     hi_ff <= cand_ff;
                  end
                  if (rank_in == lo_rank) begin
                     lo_ff <= cand_ff;
                  end
                  if (upe_pkg::CNT_W'(ci_ff) == n_ff - upe_pkg::CNT_W'(1)) begin
                     state_ff <= S_FIN;
                  end else begin
                     ci_ff    <= ci_ff + upe_pkg::IDX_W'(1);
                     state_ff <= S_CRD;
                  end
               end else begin
                  cj_ff   <= cj_ff + upe_pkg::IDX_W'(1);
                  rank_ff <= rank_in;
               end
            end
            S_FIN: begin
               median_ff <= n_ff[0] ? hi_ff : pair_sum[upe_pkg::IV_W:1];
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign stat.done   = done_ff;
   assign stat.stable = stable_ff;
   assign stat.median = median_ff;

endmodule

// ----- rtl/update_period_estimator_unit.sv -----
// Top level of the update period estimator: command handling, learned state,
// cycle choice and poll delay. Depends on upe_pkg, upe_ring and upe_scan.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | valid, stall, cmd, time_sec, reading    | in
//   rsp     | valid, stall, is_new .. manual_active   | out
//   csr     | valid, ready, index, data               | in
//
// With fewer than three intervals held the result is loaded without a median
// search; otherwise the median is found by rank counting through the single
// read port of the ring. The next beat can be taken once the result is loaded
// and the unit is back in its idle state.
// req_stall is high from acceptance until the result enters the output register,
// and while a register write is offered; csr_ready is low while an item is busy.
// Synchronous active-high reset clears all learned state; the ring needs no clearing.
// A stalled result holds in the output register and holds back the next result.
module update_period_estimator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_time_sec,
   input  logic [25:0] req_reading,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_new,
   output logic [7:0]  rsp_period_min,
   output logic [21:0] rsp_wait_ms,
   output logic        rsp_stable,
   output logic [3:0]  rsp_sample_count,
   output logic        rsp_save_request,
   output logic        rsp_manual_active,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DLY1, S_DLY2, S_OUT} state_type;

   state_type                   state_ff;
   logic [5:0]                  manual_ff;
   logic [7:0]                  start_rem_ff;
   logic [15:0]                 thr_ff;
   logic                        have_prev_ff;
   logic [25:0]                 prev_ff;
   logic [31:0]                 last_ff;
   logic [upe_pkg::IDX_W-1:0]   wp_ff;
   logic [upe_pkg::CNT_W-1:0]   filled_ff;
   logic [7:0]                  rem_ff;
   logic                        go_ff;
   logic [31:0]                 now_ff;
   logic                        is_new_ff;
   logic [7:0]                  cycle_ff;
   logic                        stable_ff;
   logic                        save_ff;
   logic signed [34:0]          d_ff;
   logic [21:0]                 delay_ff;
   logic                        rsp_valid_ff;
   logic                        o_is_new_ff;
   logic [7:0]                  o_cycle_ff;
   logic [21:0]                 o_delay_ff;
   logic                        o_stable_ff;
   logic [3:0]                  o_count_ff;
   logic                        o_save_ff;
   logic                        o_manual_ff;

   logic                        accept;
   logic                        ring_we;
   logic [25:0]                 diff;
   logic                        changed;
   logic                        new_obs;
   logic [31:0]                 iv;
   logic                        push;
   logic [upe_pkg::IV_W-1:0]    rd_data;
   logic [upe_pkg::IDX_W-1:0]   rd_addr;
   logic [7:0]                  auto_cycle;
   logic [13:0]                 cyc60;
   logic                        out_free;
   logic [5:0]                  man_wr;
   logic                        man_ok;
   upe_pkg::upe_scan_ctl_type   scan_ctl;
   upe_pkg::upe_scan_stat_type  scan_stat;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);

   assign diff    = (req_reading > prev_ff) ? req_reading - prev_ff : prev_ff - req_reading;
   assign changed = diff > {10'd0, thr_ff};
   assign new_obs = (req_cmd == upe_pkg::CMD_OBSERVE) && (!have_prev_ff || changed);
   assign iv      = req_time_sec - last_ff;
   assign push    = (iv != 32'd0) && !iv[31];
   assign ring_we = accept && (req_cmd == upe_pkg::CMD_OBSERVE) && have_prev_ff
                    && changed && push;

   assign man_wr = csr_data[5:0];
   assign man_ok = (man_wr == upe_pkg::MAN_AUTO) || (man_wr == upe_pkg::MAN_10)
                   || (man_wr == upe_pkg::MAN_20) || (man_wr == upe_pkg::MAN_30)
                   || (man_wr == upe_pkg::MAN_60);

   assign scan_ctl.go     = go_ff;
   assign scan_ctl.filled = filled_ff;
   assign scan_ctl.wp     = wp_ff;

   assign auto_cycle = upe_pkg::snap_minutes(upe_pkg::snap_idx(scan_stat.median));
   assign cyc60      = 14'(cycle_ff) * 14'd60;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   upe_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (iv[upe_pkg::IV_W-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   upe_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .stat    (scan_stat),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         manual_ff    <= upe_pkg::MAN_AUTO;
         start_rem_ff <= '0;
         thr_ff       <= upe_pkg::THRESHOLD_RESET;
         have_prev_ff <= 1'b0;
         prev_ff      <= '0;
         last_ff      <= '0;
         wp_ff        <= '0;
         filled_ff    <= '0;
         rem_ff       <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         go_ff <= accept;
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               upe_pkg::CSR_MANUAL: begin
                  if (man_ok) begin
                     manual_ff <= man_wr;
                     if (man_wr == upe_pkg::MAN_AUTO) begin
                        wp_ff     <= '0;
                        filled_ff <= '0;
                        last_ff   <= '0;
                     end
                  end
               end
               upe_pkg::CSR_START_REM: start_rem_ff <= csr_data[7:0];
               upe_pkg::CSR_THRESHOLD: thr_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  now_ff    <= req_time_sec;
                  is_new_ff <= new_obs;
                  state_ff  <= S_SCAN;
                  if (req_cmd == upe_pkg::CMD_OBSERVE) begin
                     if (!have_prev_ff) begin
                        have_prev_ff <= 1'b1;
                        prev_ff      <= req_reading;
                        last_ff      <= req_time_sec;
                     end else if (changed) begin
                        prev_ff   <= req_reading;
                        last_ff   <= req_time_sec;
                        if (push) begin
                           wp_ff <= (wp_ff == upe_pkg::IDX_W'(upe_pkg::RING_DEPTH - 1))
                                    ? '0 : wp_ff + upe_pkg::IDX_W'(1);
                           if (filled_ff < upe_pkg::CNT_W'(upe_pkg::RING_DEPTH)) begin
                              filled_ff <= filled_ff + upe_pkg::CNT_W'(1);
                           end
                        end
                     end
                  end else if (req_cmd == upe_pkg::CMD_CLEAR) begin
                     wp_ff     <= '0;
                     filled_ff <= '0;
                     last_ff   <= '0;
                     rem_ff    <= (start_rem_ff <= upe_pkg::MAX_CYCLE) ? start_rem_ff : '0;
                  end
               end
            end
            S_SCAN: begin
               if (scan_stat.done) begin
                  stable_ff <= scan_stat.stable;
                  save_ff   <= (manual_ff == upe_pkg::MAN_AUTO)
                               && (filled_ff >= upe_pkg::CNT_W'(3))
                               && scan_stat.stable && (auto_cycle != rem_ff);
                  state_ff  <= S_DLY1;
                  if (manual_ff != upe_pkg::MAN_AUTO) begin
                     cycle_ff <= {2'd0, manual_ff};
                  end else if (filled_ff < upe_pkg::CNT_W'(3)) begin
                     cycle_ff <= rem_ff;
                  end else begin
                     cycle_ff <= auto_cycle;
                     if (scan_stat.stable) begin
                        rem_ff <= auto_cycle;
                     end
                  end
               end
            end
            S_DLY1: begin
               d_ff     <= $signed(35'(last_ff)) + $signed(35'(cyc60)) + 35'sd60
                           - $signed(35'(now_ff));
               state_ff <= S_DLY2;
            end
            S_DLY2: begin
               if (cycle_ff == 8'd0) begin
                  delay_ff <= upe_pkg::DELAY_UNKNOWN;
               end else if (d_ff <= 35'sd60) begin
                  delay_ff <= upe_pkg::DELAY_MIN;
               end else if (d_ff >= 35'sd3900) begin
                  delay_ff <= upe_pkg::DELAY_MAX;
               end else begin
                  delay_ff <= 22'(d_ff[11:0]) * 22'd1000;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // load the output register once the previous beat has left
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  o_is_new_ff  <= is_new_ff;
                  o_cycle_ff   <= cycle_ff;
                  o_delay_ff   <= delay_ff;
                  o_stable_ff  <= stable_ff;
                  o_count_ff   <= 4'(filled_ff);
                  o_save_ff    <= save_ff;
                  o_manual_ff  <= (manual_ff != upe_pkg::MAN_AUTO);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_new        = o_is_new_ff;
   assign rsp_period_min    = o_cycle_ff;
   assign rsp_wait_ms       = o_delay_ff;
   assign rsp_stable        = o_stable_ff;
   assign rsp_sample_count  = o_count_ff;
   assign rsp_save_request  = o_save_ff;
   assign rsp_manual_active = o_manual_ff;

endmodule

// ----- rtl/upe_checker.sv -----
// Port-level checks of the update period estimator, bound to the top level.
// Depends only on the top level's ports.
module upe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_is_new,
   input logic [7:0]  rsp_period_min,
   input logic [21:0] rsp_wait_ms,
   input logic        rsp_stable,
   input logic [3:0]  rsp_sample_count,
   input logic        rsp_save_request,
   input logic        rsp_manual_active
);

   // a held result beat stays valid and keeps its delay, period and new flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_wait_ms)
         && $stable(rsp_period_min) && $stable(rsp_is_new))
      else $error("rsp payload changed while stalled");

   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_wait_ms >= 22'd60000) && (rsp_wait_ms <= 22'd3900000))
      else $error("delay out of clamp range");

   a_save_auto: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_save_request |-> rsp_stable && !rsp_manual_active
         && (rsp_sample_count >= 4'd3))
      else $error("save request without stable automatic estimate");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken before result was built");

endmodule

bind update_period_estimator_unit upe_checker u_upe_checker (.*);
